>>> hw/rtl/utkpq_pkg.sv
// Shared types and codes for the urgent-then-keyed priority queue.
`default_nettype none

package utkpq_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] MODE_PUSH_URGENT = 2'd0;
   localparam logic [1:0] MODE_PUSH_KEY    = 2'd1;
   localparam logic [1:0] MODE_POP         = 2'd2;

   // result status carried on rsp_tuser
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int MODE_BITS   = 2;
   localparam int KEY_BITS    = 4;
   localparam int ITEM_W      = 16;
   localparam int STATUS_BITS = 2;
   localparam int TOTAL_BITS  = 9;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 32;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctl_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/utkpq_ctrl.sv
// Sequencing state machine for the priority queue.
`default_nettype none

module utkpq_ctrl
   import utkpq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ctl_stat_type stat,
   output ctl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/utkpq_datapath.sv
// Queue pointers, fill counts, item store and result register.
`default_nettype none

module utkpq_datapath
   import utkpq_pkg::*;
#(
   parameter int LEVELS      = 16,
   parameter int QUEUE_DEPTH = 16,
   parameter int ITEM_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_cmd_type            cmd,
   output ctl_stat_type                stat,
   input  wire logic [MODE_BITS-1:0]   req_mode,
   input  wire logic [KEY_BITS-1:0]    req_key,
   input  wire logic [ITEM_W-1:0]      req_item,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [ITEM_W-1:0]           rsp_served,
   output logic [TOTAL_BITS-1:0]       rsp_total,
   output logic                        rsp_empty
);

   localparam int NQ       = LEVELS + 1;
   localparam int QW       = $clog2(NQ);
   localparam int HW       = $clog2(QUEUE_DEPTH);
   localparam int FW       = $clog2(QUEUE_DEPTH + 1);
   localparam int CW       = $clog2(NQ * QUEUE_DEPTH + 1);
   localparam int SB       = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
   localparam int AW       = QW + HW;
   localparam int MEM_SIZE = NQ * (2 ** HW);

   logic [MODE_BITS-1:0] mode_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [SB-1:0]        item_ff;

   logic [HW-1:0] heads_ff [NQ];
   logic [FW-1:0] fills_ff [NQ];
   logic [CW-1:0] total_ff;

   logic [SB-1:0] mem [MEM_SIZE];
   logic [SB-1:0] rd_data_ff;

   logic [STATUS_BITS-1:0] status_ff;
   logic                   pop_ok_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [ITEM_W-1:0]      rsp_served_ff;
   logic [TOTAL_BITS-1:0]  rsp_total_ff;
   logic                   rsp_empty_ff;

   logic [NQ-1:0]          nonempty;
   logic [QW-1:0]          lvl;
   logic [QW-1:0]          pop_q;
   logic [QW-1:0]          sel_q;
   logic [KEY_BITS+QW-1:0] key_wide;
   logic [HW:0]            slot_sum;
   logic [HW-1:0]          tail_slot;
   logic [HW-1:0]          head_next;
   logic [HW-1:0]          sel_head;
   logic [FW-1:0]          sel_fill;
   logic                   sel_full;
   logic                   is_push;
   logic                   is_pop;
   logic                   do_write;
   logic                   do_pop;
   logic [STATUS_BITS-1:0] status_in;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;

   always_comb begin
      for (int q = 0; q < NQ; q++) begin
         nonempty[q] = (fills_ff[q] != '0);
      end
   end

   // keys past the last level fold onto it
   always_comb begin
      key_wide = {{QW{1'b0}}, key_ff};
      if (key_wide >= (KEY_BITS + QW)'(LEVELS)) begin
         lvl = QW'(LEVELS - 1);
      end else begin
         lvl = QW'(key_ff);
      end
   end

   // urgent first, else lowest non-empty level
   always_comb begin
      pop_q = QW'(LEVELS);
      if (!nonempty[LEVELS]) begin
         for (int q = LEVELS - 1; q >= 0; q--) begin
            if (nonempty[q]) begin
               pop_q = QW'(q);
            end
         end
      end
   end

   always_comb begin
      is_push = (mode_ff == MODE_PUSH_URGENT) || (mode_ff == MODE_PUSH_KEY);
      is_pop  = (mode_ff == MODE_POP);
      case (mode_ff)
         MODE_PUSH_URGENT: sel_q = QW'(LEVELS);
         MODE_PUSH_KEY:    sel_q = lvl;
         default:          sel_q = pop_q;
      endcase
      sel_head = heads_ff[sel_q];
      sel_fill = fills_ff[sel_q];
      sel_full = (sel_fill == FW'(QUEUE_DEPTH));

      slot_sum = {1'b0, sel_head} + (HW + 1)'(sel_fill);
      if (slot_sum >= (HW + 1)'(QUEUE_DEPTH)) begin
         tail_slot = HW'(slot_sum - (HW + 1)'(QUEUE_DEPTH));
      end else begin
         tail_slot = HW'(slot_sum);
      end
      if (sel_head == HW'(QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = sel_head + HW'(1);
      end

      do_write  = is_push && !sel_full;
      do_pop    = is_pop && (total_ff != '0);
      status_in = STATUS_OK;
      if (is_push && sel_full) begin
         status_in = STATUS_FULL;
      end else if (is_pop && (total_ff == '0)) begin
         status_in = STATUS_EMPTY;
      end
      wr_addr = {sel_q, tail_slot};
      rd_addr = {sel_q, sel_head};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         item_ff <= SB'(req_item);
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         pop_ok_ff <= do_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && do_write) begin
         mem[wr_addr] <= item_ff;
      end
      if (cmd.execute && do_pop) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NQ; q++) begin
            heads_ff[q] <= '0;
            fills_ff[q] <= '0;
         end
         total_ff <= '0;
      end else if (cmd.execute) begin
         if (do_write) begin
            fills_ff[sel_q] <= sel_fill + FW'(1);
            total_ff        <= total_ff + CW'(1);
         end else if (do_pop) begin
            heads_ff[sel_q] <= head_next;
            fills_ff[sel_q] <= sel_fill - FW'(1);
            total_ff        <= total_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_served_ff <= pop_ok_ff ? ITEM_W'(rd_data_ff) : '0;
         rsp_total_ff  <= TOTAL_BITS'(total_ff);
         rsp_empty_ff  <= (total_ff == '0);
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_served    = rsp_served_ff;
   assign rsp_total     = rsp_total_ff;
   assign rsp_empty     = rsp_empty_ff;

endmodule

`default_nettype wire

>>> hw/rtl/urgent_then_keyed_priority_queue.sv
// Top level of the urgent-then-keyed priority queue.
//
//  channel   dir  handshake             payload
//  req       in   req_tvalid/tready     tuser: mode; tdata: key, item
//  rsp       out  rsp_tvalid/tready     tuser: status; tdata: served, total, empty
//
// Each item passes three steps: capture, execute, which updates the fill
// counts and uses the item store (one port), and finish, which loads the result.
// The next item is taken once the result is loaded into the output register.
// A result held by rsp_tready low delays the load of the following one.
// Reset is synchronous; it empties every queue at once, no clearing pass.
`default_nettype none

module urgent_then_keyed_priority_queue
   import utkpq_pkg::*;
#(
   parameter int LEVELS      = 16,
   parameter int QUEUE_DEPTH = 16,
   parameter int ITEM_BITS   = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [3:0] key, [19:4] item, [23:20] zero
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] mode
   input  wire logic [MODE_BITS-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [15:0] served_item, [24:16] total_waiting, [25] is_empty, [31:26] zero
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // [1:0] status
   output logic [STATUS_BITS-1:0]        rsp_tuser
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   logic [ITEM_W-1:0]     served;
   logic [TOTAL_BITS-1:0] total;
   logic                  empty;

   utkpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   utkpq_datapath #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ITEM_BITS   (ITEM_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_mode   (req_tuser),
      .req_key    (req_tdata[KEY_BITS-1:0]),
      .req_item   (req_tdata[KEY_BITS+ITEM_W-1:KEY_BITS]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_served (served),
      .rsp_total  (total),
      .rsp_empty  (empty)
   );

   assign rsp_tdata = {6'd0, empty, total, served};

endmodule

`default_nettype wire

>>> hw/rtl/utkpq_checker.sv
// Port-level assertions for the priority queue, bound to the top level.
`default_nettype none

module utkpq_checker
   import utkpq_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [STATUS_BITS-1:0]   rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one item in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while another is in work");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> rsp_tdata[24:16] == '0)
      else $error("empty flag with items waiting");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata[15:0] == '0 && rsp_tdata[25])
      else $error("pop on empty queue returned an item");

endmodule

bind urgent_then_keyed_priority_queue utkpq_checker u_utkpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> sim/tb_urgent_then_keyed_priority_queue.sv
// Self-checking testbench for the urgent-then-keyed priority queue.
module tb_urgent_then_keyed_priority_queue
   import utkpq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS       = 16;
   localparam int QUEUE_DEPTH  = 16;
   localparam int URGENT_QUEUE = LEVELS;

   // mode three: the block answers without touching the queues
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] served;
      logic [8:0]  total;
      logic        empty;
   } reply_type;

   class waitlist_scoreboard;
      logic [15:0] slots[LEVELS+1][QUEUE_DEPTH];
      int          heads[LEVELS+1];
      int          fills[LEVELS+1];
      int          held;
      reply_type   due_replies[$];
      int          mismatches;

      function new();
         foreach (heads[q]) begin
            heads[q] = 0;
            fills[q] = 0;
         end
         held       = 0;
         mismatches = 0;
      endfunction

      function logic [1:0] store_item(int q, logic [15:0] item);
         if (fills[q] >= QUEUE_DEPTH) return STATUS_FULL;
         slots[q][(heads[q] + fills[q]) % QUEUE_DEPTH] = item;
         fills[q]++;
         held++;
         return STATUS_OK;
      endfunction

      function logic [15:0] take_item(int q);
         logic [15:0] v;
         v        = slots[q][heads[q]];
         heads[q] = (heads[q] + 1) % QUEUE_DEPTH;
         fills[q]--;
         held--;
         return v;
      endfunction

      function void note_request(logic [1:0] mode, logic [3:0] key, logic [15:0] item);
         reply_type r;
         int        q;
         r = '0;
         q = -1;
         case (mode)
            MODE_PUSH_URGENT: r.status = store_item(URGENT_QUEUE, item);
            MODE_PUSH_KEY:
               r.status = store_item((int'(key) >= LEVELS) ? LEVELS - 1 : int'(key), item);
            MODE_POP: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  if (fills[URGENT_QUEUE] != 0) q = URGENT_QUEUE;
                  for (int k = 0; k < LEVELS; k++)
                     if (q < 0 && fills[k] != 0) q = k;
                  r.served = take_item(q);
               end
            end
            default: ;
         endcase
         r.total = 9'(held);
         r.empty = (held == 0);
         due_replies.push_back(r);
      endfunction

      function void check_reply(logic [31:0] data, logic [1:0] user);
         reply_type want;
         if (due_replies.size() == 0) begin
            $error("result with no request outstanding: tdata %h tuser %0d", data, user);
            mismatches++;
            return;
         end
         want = due_replies.pop_front();
         if (user !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, user);
            mismatches++;
         end
         if (data[15:0] !== want.served) begin
            $error("served_item: expected %h, got %h", want.served, data[15:0]);
            mismatches++;
         end
         if (data[24:16] !== want.total) begin
            $error("total_waiting: expected %0d, got %0d", want.total, data[24:16]);
            mismatches++;
         end
         if (data[25] !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, data[25]);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return due_replies.size();
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // [3:0] key, [19:4] item, [23:20] zero
   logic [MODE_BITS-1:0]     req_tuser  = '0;   // [1:0] mode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // [15:0] served, [24:16] total, [25] empty
   logic [STATUS_BITS-1:0]   rsp_tuser;         // [1:0] status

   int send_idle_pct = 15;
   int recv_idle_pct = 56;

   waitlist_scoreboard sb = new();

   urgent_then_keyed_priority_queue #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ITEM_BITS   (16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata, rsp_tuser);
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(logic [1:0] mode, logic [3:0] key, logic [15:0] item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, item, key};
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, key, item);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // segments lean toward pushes or pops so fills swing between empty and full
   task automatic run_mixed_traffic(int count);
      int          left, seg, push_pct, pick, base;
      bit          narrow;
      logic [1:0]  mode;
      logic [3:0]  key;
      logic [15:0] item;
      left = count;
      while (left > 0) begin
         seg      = $urandom_range(10, 60);
         if (seg > left) seg = left;
         push_pct = $urandom_range(0, 1) ? 75 : 25;
         narrow   = ($urandom_range(0, 2) == 0);
         base     = $urandom_range(0, 15);
         repeat (seg) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) mode = MODE_IGNORED;
            else if (pick < 3 + push_pct)
               mode = ($urandom_range(0, 3) == 0) ? MODE_PUSH_URGENT : MODE_PUSH_KEY;
            else mode = MODE_POP;
            key = narrow ? 4'(base) : 4'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
               0:       item = '0;
               1:       item = '1;
               default: item = 16'($urandom_range(0, 65535));
            endcase
            send_request(mode, key, item);
         end
         left -= seg;
      end
   endtask

   // every queue to full and one past it, then pop until empty and one more
   task automatic run_fill_and_drain();
      repeat (QUEUE_DEPTH + 1) begin
         for (int q = 0; q <= LEVELS; q++) begin
            if (q == URGENT_QUEUE)
               send_request(MODE_PUSH_URGENT, 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 65535)));
            else
               send_request(MODE_PUSH_KEY, 4'(q), 16'($urandom_range(0, 65535)));
         end
      end
      repeat ((LEVELS + 1) * QUEUE_DEPTH + 1)
         send_request(MODE_POP, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      int waited;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pop, ignored mode, extremes, service order
      send_request(MODE_POP,         4'h0, 16'h0000);
      send_request(MODE_IGNORED,     4'hF, 16'hFFFF);
      send_request(MODE_PUSH_KEY,    4'hF, 16'hFFFF);
      send_request(MODE_PUSH_KEY,    4'h0, 16'h0000);
      send_request(MODE_PUSH_KEY,    4'h7, 16'h1234);
      send_request(MODE_PUSH_URGENT, 4'h5, 16'hFFFF);
      send_request(MODE_PUSH_URGENT, 4'hA, 16'h0000);
      send_request(MODE_IGNORED,     4'h0, 16'h0000);
      repeat (6) send_request(MODE_POP, 4'hF, 16'hFFFF);
      send_request(MODE_PUSH_KEY,    4'h3, 16'h00FF);
      send_request(MODE_PUSH_KEY,    4'h3, 16'hFF00);
      send_request(MODE_PUSH_KEY,    4'h1, 16'h8001);
      repeat (3) send_request(MODE_POP, 4'h0, 16'h5A5A);

      run_mixed_traffic(500);
      wait_drained();

      send_idle_pct = 56;
      recv_idle_pct = 15;
      run_fill_and_drain();
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_mixed_traffic(550);

      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.outstanding() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.outstanding() != 0) begin
         $error("%0d expected results never arrived", sb.outstanding());
         sb.mismatches++;
      end
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/utkpq_pkg.sv
hw/rtl/utkpq_ctrl.sv
hw/rtl/utkpq_datapath.sv
hw/rtl/urgent_then_keyed_priority_queue.sv
hw/rtl/utkpq_checker.sv
sim/tb_urgent_then_keyed_priority_queue.sv
